// ----- hw/rtl/jvm_osm_pkg.sv -----
// Shared types and codes for the operand stack unit.
// Holds op codes, status codes, entry layout and field widths; no dependencies.
`timescale 1ns / 1ps
`default_nettype none
package jvm_osm_pkg;

  localparam int unsigned DefaultStackDepth = 16;

  localparam int unsigned OpW    = 4;
  localparam int unsigned ValueW = 64;
  localparam int unsigned KindW  = 3;
  localparam int unsigned PcW    = 16;
  localparam int unsigned StatW  = 2;

  // Operation codes
  localparam logic [OpW-1:0] OP_PUSH    = 4'd0;
  localparam logic [OpW-1:0] OP_POP     = 4'd1;
  localparam logic [OpW-1:0] OP_POP2    = 4'd2;
  localparam logic [OpW-1:0] OP_DUP     = 4'd3;
  localparam logic [OpW-1:0] OP_DUP_X1  = 4'd4;
  localparam logic [OpW-1:0] OP_DUP_X2  = 4'd5;
  localparam logic [OpW-1:0] OP_DUP2    = 4'd6;
  localparam logic [OpW-1:0] OP_DUP2_X1 = 4'd7;
  localparam logic [OpW-1:0] OP_DUP2_X2 = 4'd8;
  localparam logic [OpW-1:0] OP_SWAP    = 4'd9;

  // Status codes
  localparam logic [StatW-1:0] STAT_OK        = 2'd0;
  localparam logic [StatW-1:0] STAT_UNDERFLOW = 2'd1;
  localparam logic [StatW-1:0] STAT_OVERFLOW  = 2'd2;

  // Source selectors for rebuilt entries: 0..3 from the top down, or pushed
  localparam logic [2:0] SRC_V1     = 3'd0;
  localparam logic [2:0] SRC_V2     = 3'd1;
  localparam logic [2:0] SRC_V3     = 3'd2;
  localparam logic [2:0] SRC_V4     = 3'd3;
  localparam logic [2:0] SRC_PUSHED = 3'd4;

  typedef struct packed {
    logic              wide;
    logic [KindW-1:0]  kind;
    logic [ValueW-1:0] value;
  } entry_t;

endpackage
`default_nettype wire

// ----- hw/rtl/jvm_operand_stack_manipulator.sv -----
// Operand stack unit: stack entries in one synchronous memory, sequencer on top.
// Depends on jvm_osm_pkg for op codes, status codes and the entry layout.
// Sequence from the input transaction to the result: read the top entries,
// decide, write the rebuilt entries, read the new top and register the result.
// Throughput: one item at a time; the next input is taken in the cycle after the
// result is registered, which waits while the output is stalled.
// Reset clears the depth and the sequencer; memory contents are left as they are.
`timescale 1ns / 1ps
`default_nettype none
module jvm_operand_stack_manipulator #(
  parameter int unsigned STACK_DEPTH = jvm_osm_pkg::DefaultStackDepth,
  localparam int unsigned DW = $clog2(STACK_DEPTH + 1),
  localparam int unsigned OutTdataW = ((82 + DW + 7) / 8) * 8
) (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  // op[3:0], push_value[67:4], pc_in[83:68], zero pad[87:84]
  input  wire  [87:0]           s_axis_tdata_i,
  // push_kind[2:0], push_wide[3]
  input  wire  [jvm_osm_pkg::KindW:0] s_axis_tuser_i,
  output logic                  m_axis_tvalid_o,
  input  wire                   m_axis_tready_i,
  // status, pc_next, depth_out, top_value (low bits up), zero pad
  output logic [OutTdataW-1:0]  m_axis_tdata_o,
  // top_kind[2:0], top_wide[3]
  output logic [jvm_osm_pkg::KindW:0] m_axis_tuser_o
);

  localparam int unsigned AW = $clog2(STACK_DEPTH);
  localparam int unsigned CW = DW + 3;

  typedef enum logic [2:0] {
    ST_IDLE, ST_READ, ST_CALC, ST_WRITE, ST_TOP, ST_DONE
  } state_e;

  state_e                         state_q;
  logic [jvm_osm_pkg::OpW-1:0]    op_q;
  jvm_osm_pkg::entry_t            push_q;
  logic [jvm_osm_pkg::PcW-1:0]    pc_q;
  logic [2:0]                     k_q;
  jvm_osm_pkg::entry_t            x_q [4];
  logic [DW-1:0]                  depth_q;
  logic [DW-1:0]                  base_q;
  logic [2:0]                     len_q;
  logic [5:0][2:0]                seq_q;
  logic [jvm_osm_pkg::StatW-1:0]  status_q;

  logic                           m_valid_q;
  logic [jvm_osm_pkg::StatW-1:0]  o_status_q;
  logic [jvm_osm_pkg::PcW-1:0]    o_pc_q;
  logic [DW-1:0]                  o_depth_q;
  jvm_osm_pkg::entry_t            o_top_q;

  // Stack memory
  logic [$bits(jvm_osm_pkg::entry_t)-1:0] stack_mem_q [STACK_DEPTH];
  jvm_osm_pkg::entry_t            rdata_q;
  logic                           rd_en;
  logic [AW-1:0]                  rd_addr;
  logic                           wr_en;
  logic [AW-1:0]                  wr_addr;
  jvm_osm_pkg::entry_t            wr_data;

  // Form decode
  logic [2:0]                     need_c;
  logic [2:0]                     len_c;
  logic [5:0][2:0]                seq_c;
  logic                           under_c;
  logic                           over_c;
  logic [DW-1:0]                  kd;
  logic [DW-1:0]                  rd_pos;
  logic [1:0]                     cap_idx;
  logic [2:0]                     src;

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = OutTdataW'({o_top_q.value, o_depth_q, o_pc_q, o_status_q});
  assign m_axis_tuser_o  = {o_top_q.wide, o_top_q.kind};

  assign kd      = DW'(k_q);
  assign rd_pos  = depth_q - kd - DW'(1);
  assign cap_idx = 2'(k_q - 3'd1);
  assign src     = seq_q[k_q];

  // Drive memory port from the sequencer state
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = rd_pos[AW-1:0];
    if (state_q == ST_READ) begin
      rd_en = (k_q < 3'd4) && (kd < depth_q);
    end else if (state_q == ST_TOP) begin
      rd_en   = (depth_q != '0);
      rd_addr = AW'(depth_q - DW'(1));
    end
    wr_en   = (state_q == ST_WRITE);
    wr_addr = AW'(base_q + DW'(k_q));
    if (src == jvm_osm_pkg::SRC_PUSHED) begin
      wr_data = push_q;
    end else begin
      wr_data = x_q[src[1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      stack_mem_q[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_q <= stack_mem_q[rd_addr];
    end
  end

  // Choose the form from op and the wide flags of the top entries
  always_comb begin
    need_c = 3'd0;
    len_c  = 3'd0;
    seq_c  = '0;
    unique case (op_q)
      jvm_osm_pkg::OP_PUSH: begin
        len_c    = 3'd1;
        seq_c[0] = jvm_osm_pkg::SRC_PUSHED;
      end
      jvm_osm_pkg::OP_POP: need_c = 3'd1;
      jvm_osm_pkg::OP_POP2: need_c = x_q[0].wide ? 3'd1 : 3'd2;
      jvm_osm_pkg::OP_DUP: begin
        need_c = 3'd1; len_c = 3'd2;
        seq_c[0] = jvm_osm_pkg::SRC_V1; seq_c[1] = jvm_osm_pkg::SRC_V1;
      end
      jvm_osm_pkg::OP_DUP_X1: begin
        need_c = 3'd2; len_c = 3'd3;
        seq_c[0] = jvm_osm_pkg::SRC_V1; seq_c[1] = jvm_osm_pkg::SRC_V2;
        seq_c[2] = jvm_osm_pkg::SRC_V1;
      end
      jvm_osm_pkg::OP_DUP_X2: begin
        if (x_q[1].wide) begin
          need_c = 3'd2; len_c = 3'd3;
          seq_c[0] = jvm_osm_pkg::SRC_V1; seq_c[1] = jvm_osm_pkg::SRC_V2;
          seq_c[2] = jvm_osm_pkg::SRC_V1;
        end else begin
          need_c = 3'd3; len_c = 3'd4;
          seq_c[0] = jvm_osm_pkg::SRC_V1; seq_c[1] = jvm_osm_pkg::SRC_V3;
          seq_c[2] = jvm_osm_pkg::SRC_V2; seq_c[3] = jvm_osm_pkg::SRC_V1;
        end
      end
      jvm_osm_pkg::OP_DUP2: begin
        if (x_q[0].wide) begin
          need_c = 3'd1; len_c = 3'd2;
          seq_c[0] = jvm_osm_pkg::SRC_V1; seq_c[1] = jvm_osm_pkg::SRC_V1;
        end else begin
          need_c = 3'd2; len_c = 3'd4;
          seq_c[0] = jvm_osm_pkg::SRC_V2; seq_c[1] = jvm_osm_pkg::SRC_V1;
          seq_c[2] = jvm_osm_pkg::SRC_V2; seq_c[3] = jvm_osm_pkg::SRC_V1;
        end
      end
      jvm_osm_pkg::OP_DUP2_X1: begin
        if (x_q[0].wide) begin
          need_c = 3'd2; len_c = 3'd3;
          seq_c[0] = jvm_osm_pkg::SRC_V1; seq_c[1] = jvm_osm_pkg::SRC_V2;
          seq_c[2] = jvm_osm_pkg::SRC_V1;
        end else begin
          need_c = 3'd3; len_c = 3'd5;
          seq_c[0] = jvm_osm_pkg::SRC_V2; seq_c[1] = jvm_osm_pkg::SRC_V1;
          seq_c[2] = jvm_osm_pkg::SRC_V3; seq_c[3] = jvm_osm_pkg::SRC_V2;
          seq_c[4] = jvm_osm_pkg::SRC_V1;
        end
      end
      jvm_osm_pkg::OP_DUP2_X2: begin
        if (x_q[0].wide && x_q[1].wide) begin
          need_c = 3'd2; len_c = 3'd3;
          seq_c[0] = jvm_osm_pkg::SRC_V1; seq_c[1] = jvm_osm_pkg::SRC_V2;
          seq_c[2] = jvm_osm_pkg::SRC_V1;
        end else if (x_q[0].wide) begin
          need_c = 3'd3; len_c = 3'd4;
          seq_c[0] = jvm_osm_pkg::SRC_V1; seq_c[1] = jvm_osm_pkg::SRC_V3;
          seq_c[2] = jvm_osm_pkg::SRC_V2; seq_c[3] = jvm_osm_pkg::SRC_V1;
        end else if (x_q[2].wide) begin
          need_c = 3'd3; len_c = 3'd5;
          seq_c[0] = jvm_osm_pkg::SRC_V2; seq_c[1] = jvm_osm_pkg::SRC_V1;
          seq_c[2] = jvm_osm_pkg::SRC_V3; seq_c[3] = jvm_osm_pkg::SRC_V2;
          seq_c[4] = jvm_osm_pkg::SRC_V1;
        end else begin
          need_c = 3'd4; len_c = 3'd6;
          seq_c[0] = jvm_osm_pkg::SRC_V2; seq_c[1] = jvm_osm_pkg::SRC_V1;
          seq_c[2] = jvm_osm_pkg::SRC_V4; seq_c[3] = jvm_osm_pkg::SRC_V3;
          seq_c[4] = jvm_osm_pkg::SRC_V2; seq_c[5] = jvm_osm_pkg::SRC_V1;
        end
      end
      jvm_osm_pkg::OP_SWAP: begin
        need_c = 3'd2; len_c = 3'd2;
        seq_c[0] = jvm_osm_pkg::SRC_V1; seq_c[1] = jvm_osm_pkg::SRC_V2;
      end
      default: begin
        need_c = 3'd0;
        len_c  = 3'd0;
      end
    endcase
    under_c = CW'(depth_q) < CW'(need_c);
    over_c  = (CW'(depth_q) - CW'(need_c) + CW'(len_c)) > CW'(STACK_DEPTH);
  end

  // Sequencer: read top entries, decide, rewrite, read new top, deliver
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      k_q       <= '0;
      depth_q   <= '0;
      m_valid_q <= 1'b0;
    end else begin
      // drop the result once taken, unless a new one replaces it this cycle
      if (m_valid_q && m_axis_tready_i && (state_q != ST_DONE)) begin
        m_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (s_axis_tvalid_i) begin
            op_q         <= s_axis_tdata_i[3:0];
            push_q.value <= s_axis_tdata_i[67:4];
            push_q.kind  <= s_axis_tuser_i[jvm_osm_pkg::KindW-1:0];
            push_q.wide  <= s_axis_tuser_i[jvm_osm_pkg::KindW];
            pc_q         <= s_axis_tdata_i[83:68];
            k_q          <= '0;
            state_q      <= ST_READ;
          end
        end
        ST_READ: begin
          // capture the entry read in the previous cycle, zero where absent
          if (k_q != 3'd0) begin
            x_q[cap_idx] <= (kd <= depth_q) ? rdata_q : '0;
          end
          if (k_q == 3'd4) begin
            k_q     <= '0;
            state_q <= ST_CALC;
          end else begin
            k_q <= k_q + 3'd1;
          end
        end
        ST_CALC: begin
          len_q  <= len_c;
          seq_q  <= seq_c;
          base_q <= depth_q - DW'(need_c);
          k_q    <= '0;
          if (under_c) begin
            status_q <= jvm_osm_pkg::STAT_UNDERFLOW;
            state_q  <= ST_TOP;
          end else if (over_c) begin
            status_q <= jvm_osm_pkg::STAT_OVERFLOW;
            state_q  <= ST_TOP;
          end else begin
            status_q <= jvm_osm_pkg::STAT_OK;
            depth_q  <= DW'(CW'(depth_q) - CW'(need_c) + CW'(len_c));
            state_q  <= (len_c == 3'd0) ? ST_TOP : ST_WRITE;
          end
        end
        ST_WRITE: begin
          if (k_q == len_q - 3'd1) begin
            state_q <= ST_TOP;
          end else begin
            k_q <= k_q + 3'd1;
          end
        end
        ST_TOP: begin
          state_q <= ST_DONE;
        end
        ST_DONE: begin
          // hold until the output register is free
          if (!m_valid_q || m_axis_tready_i) begin
            m_valid_q  <= 1'b1;
            o_status_q <= status_q;
            o_pc_q     <= pc_q + 16'd1;
            o_depth_q  <= depth_q;
            o_top_q    <= (depth_q != '0) ? rdata_q : '0;
            state_q    <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire
